// ===== sv/pcx_rle_palette_decoder_assert.svh =====
// assertion macros shared by the run-length palette decoder modules
`ifndef PCX_RLE_PALETTE_DECODER_ASSERT_SVH
`define PCX_RLE_PALETTE_DECODER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PCX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PCX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pcx_pkg.sv =====
// shared types and constants of the run-length palette decoder
package pcx_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    // input opcodes
    localparam logic [1:0] OP_PAL  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_PIXEL = 2'd0;
    localparam logic [1:0] STAT_DONE  = 2'd1;
    localparam logic [1:0] STAT_TRUNC = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_STRIDE  = 2'd2;
    localparam logic [1:0] CFG_PALETTE = 2'd3;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_PAL = 2'd0;
    localparam logic [1:0] CMD_RUN = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;

    // run-length code fields
    localparam logic [1:0] RUN_MARK     = 2'b11;
    localparam logic [7:0] INDEX_CLEAR  = 8'hff;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic [16:0] width;
        logic [16:0] height;
        logic [15:0] stride;
        logic        use_pal;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  len;
        logic [7:0]  idx;
        logic [23:0] rgb;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] x;
        logic [15:0] y;
        logic [23:0] rgb;
        logic [7:0]  alpha;
        logic        last;
    } t_res;

endpackage

// ===== sv/pcx_in_if.sv =====
// input channel: opcode-tagged palette writes, image bytes and end markers
interface pcx_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;

    modport source (
        output valid, opcode, data_byte, palette_index,
               palette_red, palette_green, palette_blue,
        input  ready
    );
    modport sink (
        input  valid, opcode, data_byte, palette_index,
               palette_red, palette_green, palette_blue,
        output ready
    );
endinterface

// ===== sv/pcx_out_if.sv =====
// output channel: decoded pixels and end-of-image status
interface pcx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;

    modport source (
        output valid, status, pixel_x, pixel_y, red, green, blue, alpha, last,
        input  ready
    );
    modport sink (
        input  valid, status, pixel_x, pixel_y, red, green, blue, alpha, last,
        output ready
    );
endinterface

// ===== sv/pcx_front.sv =====
// front end: accepts input transactions and turns them into back-end commands
module pcx_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pcx_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output pcx_pkg::t_cmd   o_cmd
);

    logic       r_await;
    logic [5:0] r_len;
    logic       n_await;
    logic [5:0] n_len;
    logic       w_acc;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;

    // classify the accepted transaction
    always_comb begin
        n_await    = r_await;
        n_len      = r_len;
        o_push     = 1'b0;
        o_cmd.kind = pcx_pkg::CMD_PAL;
        o_cmd.len  = '0;
        o_cmd.idx  = i_in.palette_index;
        o_cmd.rgb  = {i_in.palette_red, i_in.palette_green, i_in.palette_blue};
        if (w_acc) begin
            case (i_in.opcode)
                pcx_pkg::OP_PAL: begin
                    o_push = 1'b1;
                end
                pcx_pkg::OP_BYTE: begin
                    if (r_await) begin
                        // value byte of a pending run; empty runs are dropped here
                        n_await    = 1'b0;
                        n_len      = '0;
                        o_cmd.kind = pcx_pkg::CMD_RUN;
                        o_cmd.len  = r_len;
                        o_cmd.idx  = i_in.data_byte;
                        o_push     = (r_len != '0);
                    end else if (i_in.data_byte[7:6] == pcx_pkg::RUN_MARK) begin
                        n_await = 1'b1;
                        n_len   = i_in.data_byte[5:0];
                    end else begin
                        o_cmd.kind = pcx_pkg::CMD_RUN;
                        o_cmd.len  = 6'd1;
                        o_cmd.idx  = i_in.data_byte;
                        o_push     = 1'b1;
                    end
                end
                pcx_pkg::OP_END: begin
                    n_await    = 1'b0;
                    n_len      = '0;
                    o_cmd.kind = pcx_pkg::CMD_END;
                    o_push     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // run-count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_len   <= '0;
        end else begin
            r_await <= n_await;
            r_len   <= n_len;
        end
    end

endmodule

// ===== sv/pcx_queue.sv =====
// short command queue between front and back ends
`include "pcx_rle_palette_decoder_assert.svh"
module pcx_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcx_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output pcx_pkg::t_cmd   o_cmd,
    output logic            o_empty
);

    pcx_pkg::t_cmd                r_mem [pcx_pkg::Q_DEPTH];
    logic [pcx_pkg::Q_PTR_W-1:0] r_wr;
    logic [pcx_pkg::Q_PTR_W-1:0] r_rd;
    logic [pcx_pkg::Q_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (pcx_pkg::Q_PTR_W + 1)'(pcx_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `PCX_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= (pcx_pkg::Q_PTR_W + 1)'(pcx_pkg::Q_DEPTH), "queue count overflow")
    `PCX_ASSERT_NOW(a_no_empty_pop, i_pop, !o_empty, "queue popped while empty")

endmodule

// ===== sv/pcx_back.sv =====
// back end: palette store, row walk over the padded stride and pixel output
`include "pcx_rle_palette_decoder_assert.svh"
module pcx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcx_pkg::t_cfg   i_cfg,
    input  pcx_pkg::t_cmd   i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    pcx_out_if.source       o_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [23:0]     r_pal_mem [pcx_pkg::PAL_DEPTH];
    logic [23:0]     r_pal_rd;

    logic            r_state, n_state;
    logic [15:0]     r_col, n_col;
    logic [16:0]     r_row, n_row;
    logic [5:0]      r_rem, n_rem;
    logic [7:0]      r_idx, n_idx;
    logic            r_pend_v, n_pend_v;
    pcx_pkg::t_res   r_pend, n_pend;
    logic            r_ov;
    pcx_pkg::t_res   r_o;

    logic            w_free;
    logic            w_complete;
    logic            w_visible;
    logic [16:0]     w_col_inc;
    logic            w_wrap;
    logic [23:0]     w_rgb;
    logic            w_pal_we;
    logic            w_pal_re;
    logic            w_load;
    pcx_pkg::t_res   w_res;

    assign w_free     = !r_ov || o_out.ready;
    assign w_complete = (r_row >= i_cfg.height);
    assign w_visible  = ({1'b0, r_col} < i_cfg.width);
    assign w_col_inc  = {1'b0, r_col} + 17'd1;
    // a zero stride wraps every position, the same as a stride of one
    assign w_wrap     = (w_col_inc >= {1'b0, i_cfg.stride});
    assign w_rgb      = i_cfg.use_pal ? r_pal_rd : {r_idx, r_idx, r_idx};

    // command sequencing and run walk
    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_rem    = r_rem;
        n_idx    = r_idx;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        o_pop    = 1'b0;
        w_pal_we = 1'b0;
        w_pal_re = 1'b0;
        w_load   = 1'b0;
        w_res    = r_pend;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.kind)
                        pcx_pkg::CMD_PAL: begin
                            o_pop    = 1'b1;
                            w_pal_we = 1'b1;
                        end
                        pcx_pkg::CMD_RUN: begin
                            o_pop    = 1'b1;
                            w_pal_re = 1'b1;
                            n_rem    = i_cmd.len;
                            n_idx    = i_cmd.idx;
                            n_state  = ST_RUN;
                        end
                        pcx_pkg::CMD_END: begin
                            if (w_free) begin
                                o_pop        = 1'b1;
                                w_load       = 1'b1;
                                w_res        = '0;
                                w_res.status = w_complete ? pcx_pkg::STAT_DONE
                                                          : pcx_pkg::STAT_TRUNC;
                                w_res.last   = 1'b1;
                                n_col        = '0;
                                n_row        = '0;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (w_free) begin
                    if (r_rem == '0 || w_complete) begin
                        // run finished: the held pixel is the last one
                        if (r_pend_v) begin
                            w_load     = 1'b1;
                            w_res.last = 1'b1;
                        end
                        n_pend_v = 1'b0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_rem = r_rem - 6'd1;
                        if (w_wrap) begin
                            n_col = '0;
                            n_row = r_row + 17'd1;
                        end else begin
                            n_col = w_col_inc[15:0];
                        end
                        if (w_visible) begin
                            // a newer pixel exists, so release the held one
                            if (r_pend_v) begin
                                w_load     = 1'b1;
                                w_res.last = 1'b0;
                            end
                            n_pend_v      = 1'b1;
                            n_pend.status = pcx_pkg::STAT_PIXEL;
                            n_pend.x      = r_col;
                            n_pend.y      = r_row[15:0];
                            n_pend.rgb    = w_rgb;
                            n_pend.alpha  = (r_idx == pcx_pkg::INDEX_CLEAR)
                                            ? pcx_pkg::ALPHA_CLEAR : pcx_pkg::ALPHA_OPAQUE;
                            n_pend.last   = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // palette store write port
    always_ff @(posedge i_clk) begin
        if (w_pal_we) begin
            r_pal_mem[i_cmd.idx] <= i_cmd.rgb;
        end
    end

    // palette store read port
    always_ff @(posedge i_clk) begin
        if (w_pal_re) begin
            r_pal_rd <= r_pal_mem[i_cmd.idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pend_v <= n_pend_v;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_idx  <= n_idx;
        r_pend <= n_pend;
        if (w_load) begin
            r_o <= w_res;
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.status  = r_o.status;
    assign o_out.pixel_x = r_o.x;
    assign o_out.pixel_y = r_o.y;
    assign o_out.red     = r_o.rgb[23:16];
    assign o_out.green   = r_o.rgb[15:8];
    assign o_out.blue    = r_o.rgb[7:0];
    assign o_out.alpha   = r_o.alpha;
    assign o_out.last    = r_o.last;

    `PCX_ASSERT_NOW(a_pend_in_run, r_pend_v, r_state == ST_RUN, "held pixel outside a run")
    `PCX_ASSERT_NOW(a_end_is_last, r_ov && r_o.status != pcx_pkg::STAT_PIXEL, r_o.last, "end status without last")
    `PCX_ASSERT_NEXT(a_run_flush, r_state == ST_RUN && w_free && (r_rem == '0 || w_complete), !r_pend_v && r_state == ST_IDLE, "run end did not flush")

endmodule

// ===== sv/pcx_rle_palette_decoder.sv =====
// top level of the PCX run-length decoder with palette lookup
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    opcode, data_byte, palette_index, palette_red/green/blue
//  o_out    out  valid/ready    status, pixel_x, pixel_y, red, green, blue, alpha, last
//  i_cfg_*  in   write enable   i_cfg_idx selects width, height, stride or palette select
//
// the front takes one transaction per cycle while its 4-deep command queue has room
// the back walks a run one row position per cycle while o_out is not stalled, and it
// takes no further command from the queue until that run is finished
// o_out is registered; a stalled sink holds the back, and the front once the queue is full;
// reset is synchronous and clears the queue, run state and row position; the palette store holds no reset value
module pcx_rle_palette_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcx_in_if.sink      i_in,
    pcx_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    pcx_pkg::t_cfg r_cfg;
    pcx_pkg::t_cmd w_front_cmd;
    pcx_pkg::t_cmd w_back_cmd;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= 17'd1;
            r_cfg.height  <= 17'd1;
            r_cfg.stride  <= 16'd1;
            r_cfg.use_pal <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcx_pkg::CFG_WIDTH:   r_cfg.width   <= i_cfg_data;
                pcx_pkg::CFG_HEIGHT:  r_cfg.height  <= i_cfg_data;
                pcx_pkg::CFG_STRIDE:  r_cfg.stride  <= i_cfg_data[15:0];
                pcx_pkg::CFG_PALETTE: r_cfg.use_pal <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pcx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_front_cmd)
    );

    pcx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_empty (w_empty)
    );

    pcx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (w_back_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
